### hw/rtl/iwsf_pkg.sv
// shared types and constants of the ir wall sensor front end
package iwsf_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 12;
   localparam int DIFF_BITS   = 12;
   localparam int ERROR_BITS  = 13;
   localparam int CHAN_BITS   = 3;
   localparam int CMD_BITS    = 2;
   localparam int CSR_IDX_BITS = 3;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [DIFF_BITS-1:0]   value_type;
   typedef logic [CHAN_BITS-1:0]   chan_type;
   typedef logic [CMD_BITS-1:0]    cmd_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;
   typedef logic signed [ERROR_BITS-1:0] error_type;

   // channel positions
   localparam chan_type CH_RS = 3'd0;
   localparam chan_type CH_LS = 3'd1;
   localparam chan_type CH_RF = 3'd2;
   localparam chan_type CH_LF = 3'd3;
   localparam chan_type CH_RA = 3'd4;
   localparam chan_type CH_LA = 3'd5;

   // commands
   localparam cmd_type CMD_MEASURE   = 2'd0;
   localparam cmd_type CMD_CALIBRATE = 2'd1;
   localparam cmd_type CMD_RESTORE   = 2'd2;

   // register indexes
   localparam csr_index_type REG_NOISE_FLOOR   = 3'd0;
   localparam csr_index_type REG_FRONT_DEFAULT = 3'd1;
   localparam csr_index_type REG_SIDE_DEFAULT  = 3'd2;
   localparam csr_index_type REG_DIAG_DEFAULT  = 3'd3;
   localparam csr_index_type REG_CLOSE_DEFAULT = 3'd4;

   // register reset values
   localparam value_type NOISE_FLOOR_RST   = 12'd20;
   localparam value_type FRONT_DEFAULT_RST = 12'd100;
   localparam value_type SIDE_DEFAULT_RST  = 12'd100;
   localparam value_type DIAG_DEFAULT_RST  = 12'd100;
   localparam value_type CLOSE_DEFAULT_RST = 12'd200;

   // calibration floors
   localparam value_type THRESH_MIN = 12'd60;
   localparam value_type CLOSE_MIN  = 12'd80;

   // divide by five through a reciprocal, exact for operands below 2**14
   localparam int OPERAND_BITS = 14;
   localparam int PRODUCT_BITS = 2 * OPERAND_BITS;
   localparam int RECIP_SHIFT  = 16;
   localparam logic [OPERAND_BITS-1:0] FIFTH_RECIP = 14'd13108;

   typedef logic [OPERAND_BITS-1:0] operand_type;

endpackage

### hw/rtl/iwsf_if.sv
// channel interfaces: request, response and register write
interface iwsf_req_if;
   logic                 valid;
   logic                 ready;
   iwsf_pkg::cmd_type    command;
   iwsf_pkg::chan_type   channel;
   iwsf_pkg::sample_type ambient_sample;
   iwsf_pkg::sample_type lit_sample;

   modport source (output valid, command, channel, ambient_sample, lit_sample,
                   input ready);
   modport sink   (input valid, command, channel, ambient_sample, lit_sample,
                   output ready);
endinterface

interface iwsf_rsp_if;
   logic                valid;
   logic                ready;
   iwsf_pkg::value_type channel_difference;
   logic                front_wall;
   logic                left_wall;
   logic                right_wall;
   logic                front_close;
   iwsf_pkg::error_type front_balance;
   iwsf_pkg::error_type side_balance;

   modport source (output valid, channel_difference, front_wall, left_wall, right_wall,
                   front_close, front_balance, side_balance,
                   input ready);
   modport sink   (input valid, channel_difference, front_wall, left_wall, right_wall,
                   front_close, front_balance, side_balance,
                   output ready);
endinterface

interface iwsf_csr_if;
   logic                      valid;
   logic                      ready;
   iwsf_pkg::csr_index_type   index;
   iwsf_pkg::value_type       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/iwsf_fifth_unit.sv
// shared scaling unit: registered divide by five through a reciprocal multiply
module iwsf_fifth_unit (
   input  logic                  clock,
   input  iwsf_pkg::operand_type operand,
   output iwsf_pkg::value_type   quotient
);

   logic [iwsf_pkg::PRODUCT_BITS-1:0] product_ff;
   logic [iwsf_pkg::PRODUCT_BITS-1:0] product_in;

   // widen both factors to the product width
   assign product_in = {{iwsf_pkg::OPERAND_BITS{1'b0}}, operand}
                     * {{iwsf_pkg::OPERAND_BITS{1'b0}}, iwsf_pkg::FIFTH_RECIP};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign quotient = product_ff[iwsf_pkg::RECIP_SHIFT +: iwsf_pkg::DIFF_BITS];

endmodule

### hw/rtl/ir_wall_sensor_frontend_unit.sv
// top level of the six-channel ir wall sensor front end
//
//  port     dir  handshake     payload
//  req_ch   in   valid/ready   command, channel, ambient_sample, lit_sample
//  rsp_ch   out  valid/ready   channel_difference, wall flags, front/side balance
//  csr_ch   in   valid/ready   index, data (always ready)
//
// measure, restore and unused commands go from accept through the reply state to the
// response register; calibrate first walks six channels and the close threshold through the
// one shared divide-by-five multiplier, one operand per cycle, and then a drain step.
// reset is synchronous; it clears the difference and threshold stores to zero and the registers to their defaults.
// a new request is taken while an earlier response still waits; a stalled
// response holds the block in its reply state until the output register frees.
module ir_wall_sensor_frontend_unit (
   input logic        clock,
   input logic        reset,
   iwsf_req_if.sink   req_ch,
   iwsf_rsp_if.source rsp_ch,
   iwsf_csr_if.sink   csr_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CAL   = 2'd1;
   localparam logic [1:0] ST_REPLY = 2'd2;

   localparam logic [2:0] STEP_CLOSE = 3'd6;
   localparam logic [2:0] STEP_LAST  = 3'd7;

   logic [1:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   iwsf_pkg::chan_type channel_ff, channel_in;

   iwsf_pkg::value_type noise_floor_ff, front_default_ff, side_default_ff;
   iwsf_pkg::value_type diag_default_ff, close_default_ff;

   iwsf_pkg::value_type diff_ff [iwsf_pkg::CHANNELS];
   iwsf_pkg::value_type thresh_ff [iwsf_pkg::CHANNELS];
   iwsf_pkg::value_type close_thresh_ff;

   logic                rsp_valid_ff;
   iwsf_pkg::value_type rsp_diff_ff;
   logic                rsp_front_ff, rsp_left_ff, rsp_right_ff, rsp_close_ff;
   iwsf_pkg::error_type rsp_front_err_ff, rsp_side_err_ff;

   logic                req_fire;
   logic                rsp_free;
   logic                reply_load;
   iwsf_pkg::chan_type  rd_addr;
   iwsf_pkg::value_type rd_data;
   iwsf_pkg::value_type meas_diff;
   iwsf_pkg::operand_type operand;
   iwsf_pkg::value_type quotient;
   iwsf_pkg::value_type scaled;
   iwsf_pkg::chan_type  wr_step;
   logic [iwsf_pkg::DIFF_BITS:0] front_sum;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign reply_load = (state_ff == ST_REPLY) && rsp_free;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_floor_ff   <= iwsf_pkg::NOISE_FLOOR_RST;
         front_default_ff <= iwsf_pkg::FRONT_DEFAULT_RST;
         side_default_ff  <= iwsf_pkg::SIDE_DEFAULT_RST;
         diag_default_ff  <= iwsf_pkg::DIAG_DEFAULT_RST;
         close_default_ff <= iwsf_pkg::CLOSE_DEFAULT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            iwsf_pkg::REG_NOISE_FLOOR:   noise_floor_ff   <= csr_ch.data;
            iwsf_pkg::REG_FRONT_DEFAULT: front_default_ff <= csr_ch.data;
            iwsf_pkg::REG_SIDE_DEFAULT:  side_default_ff  <= csr_ch.data;
            iwsf_pkg::REG_DIAG_DEFAULT:  diag_default_ff  <= csr_ch.data;
            iwsf_pkg::REG_CLOSE_DEFAULT: close_default_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // measured difference, zero when not positive or under the noise floor
   always_comb begin
      meas_diff = '0;
      if (req_ch.lit_sample > req_ch.ambient_sample) begin
         meas_diff = req_ch.lit_sample - req_ch.ambient_sample;
         if (meas_diff < noise_floor_ff) begin
            meas_diff = '0;
         end
      end
   end

   // indexed read port of the difference store
   assign rd_addr = (state_ff == ST_CAL) ? step_ff : channel_ff;
   always_comb begin
      if (rd_addr < iwsf_pkg::CHAN_BITS'(iwsf_pkg::CHANNELS)) begin
         rd_data = diff_ff[rd_addr];
      end else begin
         rd_data = '0;
      end
   end

   // operand feed of the shared unit: twice a difference, or four times the front average
   assign front_sum = {1'b0, diff_ff[iwsf_pkg::CH_RF]} + {1'b0, diff_ff[iwsf_pkg::CH_LF]};
   always_comb begin
      if (step_ff == STEP_CLOSE) begin
         operand = {front_sum[iwsf_pkg::DIFF_BITS:1], 2'b00};
      end else begin
         operand = {1'b0, rd_data, 1'b0};
      end
   end

   iwsf_fifth_unit u_fifth (
      .clock    (clock),
      .operand  (operand),
      .quotient (quotient)
   );

   // result of the previous step is written back this cycle
   assign wr_step = step_ff - 3'd1;
   always_comb begin
      if (wr_step == STEP_CLOSE) begin
         scaled = (quotient < iwsf_pkg::CLOSE_MIN) ? iwsf_pkg::CLOSE_MIN : quotient;
      end else begin
         scaled = (quotient < iwsf_pkg::THRESH_MIN) ? iwsf_pkg::THRESH_MIN : quotient;
      end
   end

   // difference and threshold stores
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iwsf_pkg::CHANNELS; i++) begin
            diff_ff[i]   <= '0;
            thresh_ff[i] <= '0;
         end
         close_thresh_ff <= '0;
      end else if (req_fire) begin
         if (req_ch.command == iwsf_pkg::CMD_MEASURE &&
             req_ch.channel < iwsf_pkg::CHAN_BITS'(iwsf_pkg::CHANNELS)) begin
            diff_ff[req_ch.channel] <= meas_diff;
         end else if (req_ch.command == iwsf_pkg::CMD_RESTORE) begin
            thresh_ff[iwsf_pkg::CH_RF] <= front_default_ff;
            thresh_ff[iwsf_pkg::CH_LF] <= front_default_ff;
            thresh_ff[iwsf_pkg::CH_RS] <= side_default_ff;
            thresh_ff[iwsf_pkg::CH_LS] <= side_default_ff;
            thresh_ff[iwsf_pkg::CH_RA] <= diag_default_ff;
            thresh_ff[iwsf_pkg::CH_LA] <= diag_default_ff;
            close_thresh_ff            <= close_default_ff;
         end
      end else if (state_ff == ST_CAL && step_ff != 3'd0) begin
         if (wr_step == STEP_CLOSE) begin
            close_thresh_ff <= scaled;
         end else begin
            thresh_ff[wr_step] <= scaled;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      channel_in = channel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               channel_in = req_ch.channel;
               step_in    = 3'd0;
               state_in   = (req_ch.command == iwsf_pkg::CMD_CALIBRATE) ? ST_CAL : ST_REPLY;
            end
         end
         ST_CAL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         channel_ff <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         channel_ff <= channel_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (reply_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (reply_load) begin
         rsp_diff_ff  <= rd_data;
         rsp_front_ff <= (diff_ff[iwsf_pkg::CH_RF] > thresh_ff[iwsf_pkg::CH_RF]) ||
                         (diff_ff[iwsf_pkg::CH_LF] > thresh_ff[iwsf_pkg::CH_LF]);
         rsp_left_ff  <= diff_ff[iwsf_pkg::CH_LS] > thresh_ff[iwsf_pkg::CH_LS];
         rsp_right_ff <= diff_ff[iwsf_pkg::CH_RS] > thresh_ff[iwsf_pkg::CH_RS];
         rsp_close_ff <= (diff_ff[iwsf_pkg::CH_RF] > close_thresh_ff) &&
                         (diff_ff[iwsf_pkg::CH_LF] > close_thresh_ff);
         rsp_front_err_ff <= $signed({1'b0, diff_ff[iwsf_pkg::CH_LF]})
                           - $signed({1'b0, diff_ff[iwsf_pkg::CH_RF]});
         rsp_side_err_ff  <= $signed({1'b0, diff_ff[iwsf_pkg::CH_LS]})
                           - $signed({1'b0, diff_ff[iwsf_pkg::CH_RS]});
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.channel_difference = rsp_diff_ff;
   assign rsp_ch.front_wall         = rsp_front_ff;
   assign rsp_ch.left_wall          = rsp_left_ff;
   assign rsp_ch.right_wall         = rsp_right_ff;
   assign rsp_ch.front_close        = rsp_close_ff;
   assign rsp_ch.front_balance      = rsp_front_err_ff;
   assign rsp_ch.side_balance       = rsp_side_err_ff;

endmodule
